[sv/chcf_pkg.sv]
package chcf_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int CordicStepsMax = 24;
  localparam int FullTurn = 23040;
  localparam int HalfTurn = 11520;
  localparam logic [25:0] Q16Full = 26'd23592960;
  localparam logic [25:0] Q16Half = 26'd11796480;

  // Register byte addresses.
  localparam logic [3:0] AddrMaxStep = 4'd0;
  localparam logic [3:0] AddrMinCalSpan = 4'd4;
  localparam logic [3:0] AddrDeclination = 4'd8;
  localparam logic [3:0] AddrEmaAlpha = 4'd12;

  localparam logic [15:0] MaxStepReset = 16'd600;
  localparam logic [15:0] MinCalSpanReset = 16'd200;
  localparam logic [14:0] DeclinationReset = 15'd0;
  localparam logic [8:0] EmaAlphaReset = 9'd64;

  // Arctangent of 2^-i in Q16 degrees.
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0: r = 22'd2949120;
      5'd1: r = 22'd1740967;
      5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;
      5'd4: r = 22'd234379;
      5'd5: r = 22'd117304;
      5'd6: r = 22'd58666;
      5'd7: r = 22'd29335;
      5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic check;
    logic cordic_init;
    logic cordic_step;
    logic take_plain;
    logic take_centred;
    logic box_update;
    logic filter_target;
    logic filter_mult;
    logic filter_update;
  } chcf_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic accepted;
  } chcf_status_t;

  typedef struct packed {
    logic heading_valid;
    logic [14:0] heading_filtered;
    logic [14:0] heading_plain;
    logic [14:0] heading_centred;
    logic sample_accepted;
    logic using_calibrated;
    logic signed [15:0] x_low;
    logic signed [15:0] x_high;
    logic signed [15:0] y_low;
    logic signed [15:0] y_high;
  } chcf_result_t;

endpackage

[sv/chcf_if.sv]
interface chcf_in_if (input logic clk);
  logic valid;
  logic ready;
  logic mode;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  modport source (output valid, mode, x_sample, y_sample, input ready);
  modport sink (input valid, mode, x_sample, y_sample, output ready);
endinterface

interface chcf_out_if (input logic clk);
  logic valid;
  logic ready;
  logic heading_valid;
  logic [14:0] heading_filtered;
  logic [14:0] heading_plain;
  logic [14:0] heading_centred;
  logic sample_accepted;
  logic using_calibrated;
  logic signed [15:0] x_low;
  logic signed [15:0] x_high;
  logic signed [15:0] y_low;
  logic signed [15:0] y_high;
  modport source (output valid, heading_valid, heading_filtered, heading_plain,
    heading_centred, sample_accepted, using_calibrated, x_low, x_high, y_low, y_high,
    input ready);
  modport sink (input valid, heading_valid, heading_filtered, heading_plain,
    heading_centred, sample_accepted, using_calibrated, x_low, x_high, y_low, y_high,
    output ready);
endinterface

[sv/compass_heading_calibrate_filter.sv]
// Compass heading block with hard-iron min/max calibration and smoothing.
// Input channel in: a word carries mode (0 = sample, 1 = clear) and the
// signed x_sample, y_sample magnetometer readings.
// Output channel out: one word per input word, with the filtered, plain and
// centred headings in 1/64 degree, the accept and calibration flags and box.
// Registers sit on an APB-style port: max_step at 0, min_cal_span at 4,
// declination at 8, ema_alpha at 12; pready is always high.
// An accepted sample runs two CORDIC passes, plain then centred, before
// the result is offered; a rejected sample skips both and a clear goes
// straight to the output. The two CORDIC passes share one shift-add unit,
// one step per cycle; CORDIC_STEPS defaults to 16.
// One word is in flight at a time: in.ready is high only when the block is
// idle, and the result holds on out until taken, so a stalled receiver
// stalls the input.
// Reset clears all calibration and filter state and loads the register
// defaults (600, 200, 0, 64).
module compass_heading_calibrate_filter #(
  parameter int CORDIC_STEPS = chcf_pkg::CordicStepsDefault
) (
  input  logic        clk,
  input  logic        rst,
  chcf_in_if.sink     in,
  chcf_out_if.source  out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_step, min_cal_span;
  logic [14:0] declination;
  logic [8:0] ema_alpha;
  chcf_pkg::chcf_cmd_t cmd;
  chcf_pkg::chcf_status_t status;
  chcf_pkg::chcf_result_t result;
  logic [4:0] step_idx;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= chcf_pkg::MaxStepReset;
      min_cal_span <= chcf_pkg::MinCalSpanReset;
      declination <= chcf_pkg::DeclinationReset;
      ema_alpha <= chcf_pkg::EmaAlphaReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        chcf_pkg::AddrMaxStep: max_step <= pwdata[15:0];
        chcf_pkg::AddrMinCalSpan: min_cal_span <= pwdata[15:0];
        chcf_pkg::AddrDeclination: declination <= pwdata[14:0];
        chcf_pkg::AddrEmaAlpha: ema_alpha <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr)
      chcf_pkg::AddrMaxStep: prdata = 32'(max_step);
      chcf_pkg::AddrMinCalSpan: prdata = 32'(min_cal_span);
      chcf_pkg::AddrDeclination: prdata = 32'(declination);
      chcf_pkg::AddrEmaAlpha: prdata = 32'(ema_alpha);
      default: prdata = '0;
    endcase
  end

  chcf_ctrl #(.CordicSteps(CORDIC_STEPS)) u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .status, .cmd, .step_idx
  );

  chcf_datapath #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk, .rst, .cmd, .step_idx,
    .in_mode(in.mode), .in_x(in.x_sample), .in_y(in.y_sample),
    .max_step, .min_cal_span, .declination, .ema_alpha,
    .status, .result
  );

  assign out.heading_valid = result.heading_valid;
  assign out.heading_filtered = result.heading_filtered;
  assign out.heading_plain = result.heading_plain;
  assign out.heading_centred = result.heading_centred;
  assign out.sample_accepted = result.sample_accepted;
  assign out.using_calibrated = result.using_calibrated;
  assign out.x_low = result.x_low;
  assign out.x_high = result.x_high;
  assign out.y_low = result.y_low;
  assign out.y_high = result.y_high;

endmodule

[sv/chcf_datapath.sv]
module chcf_datapath #(
  parameter int CordicSteps = chcf_pkg::CordicStepsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  chcf_pkg::chcf_cmd_t       cmd,
  input  logic [4:0]                step_idx,
  input  logic                      in_mode,
  input  logic signed [15:0]        in_x,
  input  logic signed [15:0]        in_y,
  input  logic [15:0]               max_step,
  input  logic [15:0]               min_cal_span,
  input  logic [14:0]               declination,
  input  logic [8:0]                ema_alpha,
  output chcf_pkg::chcf_status_t    status,
  output chcf_pkg::chcf_result_t    result
);

  // Sample and state registers.
  logic signed [15:0] sx, sy;
  logic is_clear, accepted, use_cal;
  logic signed [15:0] last_x, last_y, bx_min, bx_max, by_min, by_max;
  logic have_last, have_box, filter_primed;
  logic [14:0] plain_h, centred_h, filt_h, target;
  logic signed [15:0] diff;
  logic signed [25:0] prod;

  // CORDIC registers; x,y carry the sample scaled by 256 plus growth.
  logic signed [26:0] cx, cy;
  logic signed [26:0] cz;
  logic signed [26:0] cx_next, cy_next, cz_next;
  logic signed [26:0] dx, dy;
  logic [14:0] cordic_heading;

  // Step check on absolute per-axis distance.
  logic signed [16:0] stx, sty;
  logic [16:0] ax, ay;
  logic step_ok;
  assign stx = 17'(sx) - 17'(last_x);
  assign sty = 17'(sy) - 17'(last_y);
  assign ax = stx[16] ? 17'(-stx) : 17'(stx);
  assign ay = sty[16] ? 17'(-sty) : 17'(sty);
  assign step_ok = !have_last || (ax <= 17'(max_step) && ay <= 17'(max_step));

  // Operands for the centred heading use the updated box.
  logic signed [16:0] sumx, sumy, offx17, offy17;
  logic signed [15:0] cen_x, cen_y, opx, opy;
  assign sumx = 17'(bx_min) + 17'(bx_max);
  assign sumy = 17'(by_min) + 17'(by_max);
  assign offx17 = (sumx + 17'(sumx[16])) >>> 1;
  assign offy17 = (sumy + 17'(sumy[16])) >>> 1;
  assign cen_x = sx - offx17[15:0];
  assign cen_y = sy - offy17[15:0];
  assign opx = cmd.take_plain ? cen_x : sx;
  assign opy = cmd.take_plain ? cen_y : sy;

  // Left half-plane operands are negated before the first step.
  logic signed [16:0] ix, iy;
  assign ix = opx[15] ? 17'(-17'(opx)) : 17'(opx);
  assign iy = opx[15] ? 17'(-17'(opy)) : 17'(opy);

  // One vectoring step.
  assign dx = cx >>> step_idx;
  assign dy = cy >>> step_idx;
  always_comb begin
    if (!cy[26]) begin
      cx_next = cx + dy;
      cy_next = cy - dx;
      cz_next = cz + 27'(chcf_pkg::atan_q16(step_idx));
    end else begin
      cx_next = cx - dy;
      cy_next = cy + dx;
      cz_next = cz - 27'(chcf_pkg::atan_q16(step_idx));
    end
  end

  // Wrap the angle into one turn and convert to 1/64 degree.
  logic signed [26:0] zw;
  logic [16:0] hq;
  always_comb begin
    zw = cz;
    if (zw < 0) zw = zw + 27'(chcf_pkg::Q16Full);
    else if (zw >= 27'(chcf_pkg::Q16Full)) zw = zw - 27'(chcf_pkg::Q16Full);
    hq = 17'((zw + 27'sd512) >>> 10);
    if (hq >= 17'(chcf_pkg::FullTurn)) hq = hq - 17'(chcf_pkg::FullTurn);
    cordic_heading = hq[14:0];
  end

  // Calibration decision from the current box.
  logic [16:0] spx, spy;
  logic cal_ok;
  assign spx = 17'(17'(bx_max) - 17'(bx_min));
  assign spy = 17'(17'(by_max) - 17'(by_min));
  assign cal_ok = have_box && !spx[16] && !spy[16] && spx != 0 && spy != 0
      && spx >= 17'(min_cal_span) && spy >= 17'(min_cal_span);

  // Target with declination, wrapped into one turn.
  logic signed [16:0] tgt;
  always_comb begin
    tgt = 17'(cal_ok ? centred_h : plain_h) + {{2{declination[14]}}, declination};
    if (tgt < 0) tgt = tgt + 17'(chcf_pkg::FullTurn);
    if (tgt >= 17'(chcf_pkg::FullTurn)) tgt = tgt - 17'(chcf_pkg::FullTurn);
  end

  // Shortest-path difference and filter update.
  logic signed [15:0] d_raw;
  logic signed [17:0] step_v;
  logic signed [17:0] newf;
  always_comb begin
    d_raw = 16'(16'(target) - 16'(filt_h));
    if (d_raw > 16'(chcf_pkg::HalfTurn)) d_raw = d_raw - 16'(chcf_pkg::FullTurn);
    else if (d_raw < -16'(chcf_pkg::HalfTurn)) d_raw = d_raw + 16'(chcf_pkg::FullTurn);
    step_v = 18'((prod + 26'sd128) >>> 8);
    newf = 18'(filt_h) + step_v;
    if (newf < 0) newf = newf + 18'(chcf_pkg::FullTurn);
    else if (newf >= 18'(chcf_pkg::FullTurn)) newf = newf - 18'(chcf_pkg::FullTurn);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      last_x <= '0; last_y <= '0; have_last <= 1'b0; have_box <= 1'b0;
      bx_min <= '0; bx_max <= '0; by_min <= '0; by_max <= '0;
      plain_h <= '0; centred_h <= '0; filt_h <= '0; filter_primed <= 1'b0;
      accepted <= 1'b0; use_cal <= 1'b0;
    end else begin
      if (cmd.check) begin
        accepted <= step_ok;
        if (step_ok) begin
          last_x <= sx; last_y <= sy; have_last <= 1'b1;
        end
      end
      if (cmd.box_update) begin
        if (!have_box) begin
          bx_min <= sx; bx_max <= sx; by_min <= sy; by_max <= sy;
          have_box <= 1'b1;
        end else begin
          if (sx < bx_min) bx_min <= sx;
          if (sx > bx_max) bx_max <= sx;
          if (sy < by_min) by_min <= sy;
          if (sy > by_max) by_max <= sy;
        end
      end
      if (cmd.take_plain) plain_h <= cordic_heading;
      if (cmd.take_centred) centred_h <= cordic_heading;
      if (cmd.filter_target) begin
        target <= tgt[14:0];
        use_cal <= cal_ok;
      end
      if (cmd.filter_mult) begin
        diff <= d_raw;
        prod <= 26'($signed({1'b0, ema_alpha})) * 26'(d_raw);
      end
      if (cmd.filter_update) begin
        if (!filter_primed) begin
          filt_h <= target;
          filter_primed <= 1'b1;
        end else begin
          filt_h <= newf[14:0];
        end
      end
    end
  end

  // Sample capture and CORDIC registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= in_x; sy <= in_y; is_clear <= in_mode;
    end
    if (cmd.cordic_init) begin
      cx <= 27'(ix) <<< 8;
      cy <= 27'(iy) <<< 8;
      cz <= opx[15] ? 27'(chcf_pkg::Q16Half) : '0;
    end else if (cmd.cordic_step) begin
      if (cx == 0 && cy == 0 && cz == 0) begin
        cz <= '0;
      end else begin
        cx <= cx_next; cy <= cy_next; cz <= cz_next;
      end
    end
  end

  assign status.is_clear = is_clear;
  assign status.accepted = accepted;

  assign result.heading_valid = !is_clear;
  assign result.heading_filtered = filt_h;
  assign result.heading_plain = plain_h;
  assign result.heading_centred = centred_h;
  assign result.sample_accepted = accepted;
  assign result.using_calibrated = use_cal;
  assign result.x_low = bx_min;
  assign result.x_high = bx_max;
  assign result.y_low = by_min;
  assign result.y_high = by_max;

  logic unused;
  assign unused = ^{diff, 1'(CordicSteps)};

endmodule

[sv/chcf_ctrl.sv]
module chcf_ctrl #(
  parameter int CordicSteps = chcf_pkg::CordicStepsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  chcf_pkg::chcf_status_t status,
  output chcf_pkg::chcf_cmd_t    cmd,
  output logic [4:0]             step_idx
);

  localparam int Steps = (CordicSteps < chcf_pkg::CordicStepsMax)
      ? CordicSteps : chcf_pkg::CordicStepsMax;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CHECK, S_PINIT, S_PSTEP, S_PTAKE, S_CINIT, S_CSTEP,
    S_CTAKE, S_TGT, S_MULT, S_UPD, S_OUT
  } state_t;

  state_t state;
  logic [4:0] cnt;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign step_idx = cnt;

  // Commands decode from the current state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_DECODE: cmd.clear = status.is_clear;
      S_CHECK: cmd.check = 1'b1;
      S_PINIT: cmd.cordic_init = 1'b1;
      S_PSTEP: cmd.cordic_step = 1'b1;
      S_PTAKE: begin
        cmd.take_plain = 1'b1;
        cmd.box_update = 1'b1;
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cmd.take_plain = 1'b1;
      end
      S_CSTEP: cmd.cordic_step = 1'b1;
      S_CTAKE: cmd.take_centred = 1'b1;
      S_TGT: cmd.filter_target = 1'b1;
      S_MULT: cmd.filter_mult = 1'b1;
      S_UPD: cmd.filter_update = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: state <= status.is_clear ? S_OUT : S_CHECK;
        S_CHECK: state <= S_PINIT;
        S_PINIT: begin
          state <= status.accepted ? S_PSTEP : S_TGT;
          cnt <= '0;
        end
        S_PSTEP: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(Steps - 1)) state <= S_PTAKE;
        end
        S_PTAKE: state <= S_CINIT;
        S_CINIT: begin
          state <= S_CSTEP;
          cnt <= '0;
        end
        S_CSTEP: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(Steps - 1)) state <= S_CTAKE;
        end
        S_CTAKE: state <= S_TGT;
        S_TGT: state <= S_MULT;
        S_MULT: state <= S_UPD;
        S_UPD: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/chcf_checker.sv]
module chcf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic heading_valid,
  input logic sample_accepted,
  input logic [14:0] heading_filtered
);

  // No new word is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A taken word never yields a result in the very next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // The filtered heading stays inside one turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_filtered < 15'd23040) else $error("heading out of range");

  // A clear result carries no accept flag.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !heading_valid) |-> !sample_accepted) else $error("clear flagged");

  // Output valid stays high while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

bind compass_heading_calibrate_filter chcf_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .heading_valid(out.heading_valid), .sample_accepted(out.sample_accepted),
  .heading_filtered(out.heading_filtered)
);

[tb/compass_heading_calibrate_filter_test.sv]
`timescale 1ns / 1ps

module compass_heading_calibrate_filter_test;

  localparam int Steps = 16;
  localparam int SettleCycles = 80;
  localparam int StallLimit = 4000;

  typedef struct {
    logic mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } mag_word_t;

  // Arctangent of 2^-i in Q16 degrees, one entry per CORDIC step.
  localparam longint AtanTable [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  chcf_in_if in_ch (clk);
  chcf_out_if out_ch (clk);

  compass_heading_calibrate_filter i_dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mag_word_t pending_words[$];
  chcf_pkg::chcf_result_t expected_headings[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // Shadow copy of the registers and of the calibration and filter state.
  logic [15:0] cfg_max_step;
  logic [15:0] cfg_min_span;
  logic signed [14:0] cfg_declination;
  logic [8:0] cfg_alpha;
  int last_x, last_y, box_xl, box_xh, box_yl, box_yh;
  bit have_last, have_box, primed;
  int plain_heading, centred_heading, smooth_heading;

  // Generator position, the last sample queued.
  int gen_x = 0;
  int gen_y = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int cordic_heading(input int xi, input int yi);
    longint x, y, z, nx, dx, dy, h;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 11796480;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < Steps; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        nx = x + dy;
        y = y - dx;
        z = z + AtanTable[i];
      end else begin
        nx = x - dy;
        y = y + dx;
        z = z - AtanTable[i];
      end
      x = nx;
    end
    while (z < 0) z = z + 23592960;
    while (z >= 23592960) z = z - 23592960;
    h = (z + 512) >> 10;
    if (h >= chcf_pkg::FullTurn) h = h - chcf_pkg::FullTurn;
    return int'(h);
  endfunction

  function automatic void clear_state();
    last_x = 0; last_y = 0;
    box_xl = 0; box_xh = 0; box_yl = 0; box_yh = 0;
    have_last = 0; have_box = 0; primed = 0;
    plain_heading = 0; centred_heading = 0; smooth_heading = 0;
  endfunction

  // Works out the result word for one accepted input word.
  function automatic chcf_pkg::chcf_result_t heading_update(input mag_word_t w);
    chcf_pkg::chcf_result_t r;
    int x, y, sx, sy, target, d, spanx, spany;
    shortint cx, cy;
    longint st;
    bit ok, cal;
    r = '0;
    if (w.mode) begin
      clear_state();
      return r;
    end
    x = w.x;
    y = w.y;
    ok = 1;
    cal = 0;
    if (have_last) begin
      sx = x - last_x;
      sy = y - last_y;
      if (sx < 0) sx = -sx;
      if (sy < 0) sy = -sy;
      if (sx > cfg_max_step || sy > cfg_max_step) ok = 0;
    end
    if (ok) begin
      last_x = x;
      last_y = y;
      have_last = 1;
      plain_heading = cordic_heading(x, y);
      if (!have_box) begin
        box_xl = x; box_xh = x; box_yl = y; box_yh = y;
        have_box = 1;
      end else begin
        if (x < box_xl) box_xl = x;
        if (x > box_xh) box_xh = x;
        if (y < box_yl) box_yl = y;
        if (y > box_yh) box_yh = y;
      end
      cx = shortint'(x - (box_xl + box_xh) / 2);
      cy = shortint'(y - (box_yl + box_yh) / 2);
      centred_heading = cordic_heading(cx, cy);
    end
    target = plain_heading;
    if (have_box) begin
      spanx = box_xh - box_xl;
      spany = box_yh - box_yl;
      if (spanx > 0 && spany > 0 && spanx >= cfg_min_span && spany >= cfg_min_span) begin
        target = centred_heading;
        cal = 1;
      end
    end
    target = target + cfg_declination;
    if (target < 0) target = target + chcf_pkg::FullTurn;
    if (target >= chcf_pkg::FullTurn) target = target - chcf_pkg::FullTurn;
    if (!primed) begin
      smooth_heading = target;
      primed = 1;
    end else begin
      d = target - smooth_heading;
      if (d > chcf_pkg::HalfTurn) d = d - chcf_pkg::FullTurn;
      else if (d < -chcf_pkg::HalfTurn) d = d + chcf_pkg::FullTurn;
      st = (longint'(cfg_alpha) * d + 128) >>> 8;
      smooth_heading = int'((smooth_heading + st + 2 * chcf_pkg::FullTurn)
          % chcf_pkg::FullTurn);
    end
    r.heading_valid = 1;
    r.heading_filtered = smooth_heading[14:0];
    r.heading_plain = plain_heading[14:0];
    r.heading_centred = centred_heading[14:0];
    r.sample_accepted = ok;
    r.using_calibrated = cal;
    r.x_low = box_xl[15:0];
    r.x_high = box_xh[15:0];
    r.y_low = box_yl[15:0];
    r.y_high = box_yh[15:0];
    return r;
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void queue_word(input bit mode, input int x, input int y);
    mag_word_t w;
    w.mode = mode;
    w.x = x[15:0];
    w.y = y[15:0];
    pending_words.push_back(w);
    if (!mode) begin
      gen_x = x;
      gen_y = y;
    end
  endfunction

  // Mostly small steps around the last sample, with noise, jumps and clears.
  function automatic void queue_random(input int count);
    int pick, lim;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      lim = (cfg_max_step > 900) ? 900 : int'(cfg_max_step);
      if (pick < 78)
        queue_word(0, clamp16(gen_x + $urandom_range(2 * lim) - lim),
          clamp16(gen_y + $urandom_range(2 * lim) - lim));
      else if (pick < 90)
        queue_word(0, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
      else if (pick < 95)
        queue_word(0, ($urandom_range(1)) ? 32767 : -32768, ($urandom_range(1)) ? 32767 : -32768);
      else
        queue_word(1, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
    end
  endfunction

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (addr)
      chcf_pkg::AddrMaxStep: cfg_max_step = data[15:0];
      chcf_pkg::AddrMinCalSpan: cfg_min_span = data[15:0];
      chcf_pkg::AddrDeclination: cfg_declination = data[14:0];
      chcf_pkg::AddrEmaAlpha: cfg_alpha = data[8:0];
      default: ;
    endcase
  endtask

  // Waits until every queued word has been answered, then lets the block settle.
  task automatic drain();
    while (pending_words.size() != 0 || expected_headings.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_regs(input int ms, input int span, input int decl, input int alpha);
    reg_write(chcf_pkg::AddrMaxStep, ms);
    reg_write(chcf_pkg::AddrMinCalSpan, span);
    reg_write(chcf_pkg::AddrDeclination, decl);
    reg_write(chcf_pkg::AddrEmaAlpha, alpha);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Sender: presents the next pending word, holding it until taken.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1;
        in_ch.mode <= pending_words[0].mode;
        in_ch.x_sample <= pending_words[0].x;
        in_ch.y_sample <= pending_words[0].y;
        pending_words.pop_front();
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Predicts each accepted word and checks each delivered result.
  always @(posedge clk) begin
    chcf_pkg::chcf_result_t exp_r;
    mag_word_t w;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (in_ch.valid && in_ch.ready) begin
        w.mode = in_ch.mode;
        w.x = in_ch.x_sample;
        w.y = in_ch.y_sample;
        expected_headings.push_back(heading_update(w));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_headings.size() == 0) begin
          $display("%0t: unexpected result word", $realtime);
          errors++;
        end else begin
          exp_r = expected_headings.pop_front();
          compare_field("heading_valid", exp_r.heading_valid, out_ch.heading_valid);
          compare_field("heading_filtered", exp_r.heading_filtered, out_ch.heading_filtered);
          compare_field("heading_plain", exp_r.heading_plain, out_ch.heading_plain);
          compare_field("heading_centred", exp_r.heading_centred, out_ch.heading_centred);
          compare_field("sample_accepted", exp_r.sample_accepted, out_ch.sample_accepted);
          compare_field("using_calibrated", exp_r.using_calibrated, out_ch.using_calibrated);
          compare_field("x_low", exp_r.x_low, out_ch.x_low);
          compare_field("x_high", exp_r.x_high, out_ch.x_high);
          compare_field("y_low", exp_r.y_low, out_ch.y_low);
          compare_field("y_high", exp_r.y_high, out_ch.y_high);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("compass_heading_calibrate_filter_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.x_sample = '0;
    in_ch.y_sample = '0;
    out_ch.ready = 0;
    cfg_max_step = chcf_pkg::MaxStepReset;
    cfg_min_span = chcf_pkg::MinCalSpanReset;
    cfg_declination = chcf_pkg::DeclinationReset;
    cfg_alpha = chcf_pkg::EmaAlphaReset;
    clear_state();
    repeat (7) @(posedge clk);
    rst <= 0;

    // Directed words at reset settings: zero vector, axes, extremes, outliers, clear.
    send_idle_pct = 19;
    recv_idle_pct = 62;
    queue_word(0, 0, 0);
    queue_word(0, 500, 0);
    queue_word(0, 500, 500);
    queue_word(0, 0, 500);
    queue_word(0, -100, 400);
    queue_word(0, -300, 0);
    queue_word(0, -300, -300);
    queue_word(0, 0, -300);
    queue_word(0, 5000, 5000);
    queue_word(0, 300, -300);
    queue_word(1, 1234, -1234);
    queue_word(0, -32768, -32768);
    queue_word(0, -32768, 32767);
    queue_word(0, -32168, 32767);
    queue_word(1, 0, 0);
    queue_word(0, 32767, -32768);
    queue_word(0, 32767, 32767);
    queue_word(0, -1, 0);
    queue_word(0, -1, -1);
    queue_random(80);
    drain();

    // Widest step, no span needed, most positive declination, full weight.
    set_regs(65535, 0, 11520, 256);
    queue_word(0, -32768, -32768);
    queue_word(0, 32767, 32767);
    queue_random(100);
    drain();

    // No step allowed, unreachable span, most negative declination, zero filter weight.
    send_idle_pct = 62;
    recv_idle_pct = 19;
    set_regs(0, 65535, -11520, 0);
    queue_word(1, 0, 0);
    queue_random(100);
    drain();

    // Register values beyond the nominal range.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(400, 150, 32'h4000 | $urandom_range(16383), 511);
    queue_random(50);
    drain();
    set_regs($urandom_range(1500), $urandom_range(600), $urandom_range(32767), $urandom_range(256));
    queue_random(50);
    drain();

    if (errors == 0) begin
      $display("compass_heading_calibrate_filter_test passed");
    end else begin
      $display("compass_heading_calibrate_filter_test failed");
    end
    $finish;
  end

endmodule
